/* rtl/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the sorted pair sum finder.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int MAX_ITEMS_DEF = 64;   // default data set capacity
  localparam int RESULT_CAP    = 32;   // pairs reported per data set at most
  localparam int DATA_W        = 32;
  localparam int CNT_RES_W     = $clog2(RESULT_CAP + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_CHECK,
    ST_CMP,
    ST_FINAL
  } sps_state_t;

endpackage

/* rtl/sorted_pair_sum_finder_top.sv */
// Load: one input beat per cycle; the beat marked last starts the walk.
// Walk: a setup state, then per pointer step a check state (registered read) and a compare
// state (33-bit add and compare), at most count-1 steps, then a last check and the final result.
// The block takes no input beat from the last beat until the final result is registered.
// Results leave through one output register; a stalled result holds the walk.
// Reset (rst_n, synchronous): target 0, store empty, no result pending.
// ----------------------------------------------------------------------------
// sorted_pair_sum_finder_top
// Two-pointer pair search over an ascending data set held in a local memory.
// ----------------------------------------------------------------------------
module sorted_pair_sum_finder_top
  import sps_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic signed [DATA_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_found,
  output logic signed [DATA_W-1:0] out_low_value,
  output logic signed [DATA_W-1:0] out_high_value,
  output logic                     out_overflow,
  output logic                     out_last_result
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [DATA_W-1:0] mem [MAX_ITEMS];
  logic [DATA_W-1:0] rd_lo_r, rd_hi_r;

  sps_state_t state_r, state_nxt;
  logic signed [DATA_W-1:0] target_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 drop_r, drop_nxt;
  logic [AW-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_RES_W-1:0] n_r, n_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [DATA_W-1:0]    pend_lo_r, pend_lo_nxt, pend_hi_r, pend_hi_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [DATA_W-1:0]    out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;
  logic                 out_ovf_r, out_ovf_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 mem_we;
  logic                 in_acc;
  logic                 out_free;
  logic signed [DATA_W:0] sum, tgt;

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign sum = $signed({rd_lo_r[DATA_W-1], rd_lo_r}) + $signed({rd_hi_r[DATA_W-1], rd_hi_r});
  assign tgt = $signed({target_r[DATA_W-1], target_r});

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_lo_nxt   = pend_lo_r;
    pend_hi_nxt   = pend_hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_lo_nxt    = out_lo_r;
    out_hi_nxt    = out_hi_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        lo_nxt     = '0;
        hi_nxt     = (cnt_r == '0) ? '0 : AW'(cnt_r - CW'(1));
        n_nxt      = '0;
        pend_v_nxt = 1'b0;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (lo_r < hi_r && n_r < CNT_RES_W'(RESULT_CAP)) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_FINAL;
        end
      end
      ST_CMP: begin
        if (sum == tgt) begin
          // a new match releases the held one, which is then known not to be last
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b1;
              out_lo_nxt    = pend_lo_r;
              out_hi_nxt    = pend_hi_r;
              out_ovf_nxt   = drop_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_lo_nxt = rd_lo_r;
            pend_hi_nxt = rd_hi_r;
            n_nxt       = n_r + CNT_RES_W'(1);
            lo_nxt      = lo_r + AW'(1);
            hi_nxt      = hi_r - AW'(1);
            state_nxt   = ST_CHECK;
          end
        end else if (sum < tgt) begin
          lo_nxt    = lo_r + AW'(1);
          state_nxt = ST_CHECK;
        end else begin
          hi_nxt    = hi_r - AW'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = pend_v_r;
          out_lo_nxt    = pend_v_r ? pend_lo_r : '0;
          out_hi_nxt    = pend_v_r ? pend_hi_r : '0;
          out_ovf_nxt   = drop_r;
          out_last_nxt  = 1'b1;
          cnt_nxt       = '0;
          drop_nxt      = 1'b0;
          lo_nxt        = '0;
          hi_nxt        = '0;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      target_r    <= '0;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      n_r         <= n_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_lo_r  <= pend_lo_nxt;
    pend_hi_r  <= pend_hi_nxt;
    out_found_r <= out_found_nxt;
    out_lo_r   <= out_lo_nxt;
    out_hi_r   <= out_hi_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  // element store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= in_value;
    end
    rd_lo_r <= mem[lo_r];
    rd_hi_r <= mem[hi_r];
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_low_value   = out_lo_r;
  assign out_high_value  = out_hi_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_result = out_last_r;

endmodule

/* dv/tb_sorted_pair_sum_finder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_pair_sum_finder_top
// Self-checking bench for the two-pointer pair search. It loads data sets
// (mostly ascending, some unsorted, one past capacity) under several targets.
// A scoreboard predicts the pairs of each walk and checks every result beat.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic               found;
  logic signed [31:0] low_value;
  logic signed [31:0] high_value;
  logic               overflow;
  logic               last_result;
} pair_result_t;

class pair_sum_scoreboard;
  int           target;
  int           elements [sps_pkg::MAX_ITEMS_DEF];
  int           n_elements;
  bit           dropped;
  pair_result_t expected_q [$];
  int           errors;

  function new();
    target     = 0;
    n_elements = 0;
    dropped    = 1'b0;
    errors     = 0;
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // Accepted input beat; the last beat of a set runs the pointer walk.
  function void note_input(int value, bit last);
    int           lo;
    int           hi;
    int           pairs;
    longint       sum;
    bit           have;
    pair_result_t held;
    if (n_elements < sps_pkg::MAX_ITEMS_DEF) begin
      elements[n_elements] = value;
      n_elements++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    lo    = 0;
    hi    = n_elements - 1;
    pairs = 0;
    have  = 1'b0;
    while (lo < hi && pairs < sps_pkg::RESULT_CAP) begin
      sum = longint'(elements[lo]) + longint'(elements[hi]);
      if (sum == longint'(target)) begin
        // hold back one pair so the final one can get its last mark
        if (have) expected_q.push_back(held);
        held = '{1'b1, elements[lo], elements[hi], dropped, 1'b0};
        have = 1'b1;
        pairs++;
        lo++;
        hi--;
      end else if (sum < longint'(target)) begin
        lo++;
      end else begin
        hi--;
      end
    end
    if (!have) held = '{1'b0, 32'sd0, 32'sd0, dropped, 1'b1};
    held.last_result = 1'b1;
    expected_q.push_back(held);
    n_elements = 0;
    dropped    = 1'b0;
  endfunction

  function void check_result(pair_result_t got);
    pair_result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result found=%0b low=%0d high=%0d ovf=%0b last=%0b",
                       got.found, got.low_value, got.high_value, got.overflow,
                       got.last_result));
      return;
    end
    want = expected_q.pop_front();
    if (got.found !== want.found || got.low_value !== want.low_value ||
        got.high_value !== want.high_value || got.overflow !== want.overflow ||
        got.last_result !== want.last_result) begin
      report($sformatf({"exp found=%0b low=%0d high=%0d ovf=%0b last=%0b, ",
                        "got found=%0b low=%0d high=%0d ovf=%0b last=%0b"},
                       want.found, want.low_value, want.high_value, want.overflow,
                       want.last_result, got.found, got.low_value, got.high_value,
                       got.overflow, got.last_result));
    end
  endfunction
endclass

module tb_sorted_pair_sum_finder_top
  import sps_pkg::*;
;

  localparam int VAL_MIN         = 32'sh8000_0000;
  localparam int VAL_MAX         = 32'sh7fff_ffff;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_BEATS    = 150;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic signed [DATA_W-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_found;
  logic signed [DATA_W-1:0] out_low_value;
  logic signed [DATA_W-1:0] out_high_value;
  logic                     out_overflow;
  logic                     out_last_result;

  pair_sum_scoreboard sb = new();
  bit                 gapless      = 1'b0;
  bit                 hold_off_req = 1'b0;
  int                 beats_sent   = 0;

  sorted_pair_sum_finder_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_low_value   (out_low_value),
    .out_high_value  (out_high_value),
    .out_overflow    (out_overflow),
    .out_last_result (out_last_result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : result_monitor
    pair_result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_found, out_low_value, out_high_value, out_overflow, out_last_result};
      sb.check_result(seen);
    end
  end

  // Receiver back-pressure: short random stalls, clear stretches, long holds.
  initial begin : result_stall
    int run;
    int r;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall    = 1'b0;
        hold_off_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          out_stall = 1'b0;
          run       = $urandom_range(10, 60);
        end else if (r < 85) begin
          out_stall = $urandom_range(0, 1);
          run       = $urandom_range(1, 3);
        end else begin
          out_stall = 1'b1;
          run       = $urandom_range(8, 40);
        end
        for (int i = 1; i < run && !hold_off_req; i++) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge with valid possibly
  // still high, so the next beat follows without a bubble.
  task automatic send_item(input int value, input bit last);
    int gap;
    in_valid = 1'b1;
    in_value = value;
    in_last  = last;
    do @(posedge clk); while (in_stall);
    sb.note_input(value, last);
    beats_sent++;
    @(negedge clk);
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_set(input int vals [$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  // Only while idle: all results back and the walk finished.
  task automatic write_target(input int value);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.target = value;
  endtask

  // mode 0: values with their partner for the target, 1: clustered near
  // target/2, 2: unsorted, otherwise random ascending
  function automatic void make_set(input int count, input int target, input int mode,
                                   ref int vals [$]);
    longint v;
    longint partner;
    int     mid;
    vals.delete();
    mid = int'(longint'(target) >>> 1);
    while (vals.size() < count) begin
      case (mode)
        0: begin
          v = longint'(int'($urandom()));
          vals.push_back(int'(v));
          partner = longint'(target) - v;
          if (partner >= VAL_MIN && partner <= VAL_MAX) vals.push_back(int'(partner));
        end
        1: begin
          v = longint'(mid) + longint'($urandom_range(0, 16)) - 8;
          if (v < VAL_MIN) v = VAL_MIN;
          if (v > VAL_MAX) v = VAL_MAX;
          vals.push_back(int'(v));
        end
        default: vals.push_back(int'($urandom()));
      endcase
    end
    while (vals.size() > count) void'(vals.pop_back());
    if (mode != 2) vals.sort();
  endfunction

  initial begin : stimulus
    int vals [$];
    int target;
    int count;
    int mode;
    int r;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_value  = '0;
    in_last   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // target still at its reset value of zero
    vals = '{7};                       // lone element, no pair possible
    send_set(vals);
    vals = '{-3, -1, 0, 1, 3};         // two pairs
    send_set(vals);
    write_target(-1);
    vals = '{VAL_MIN, 0, VAL_MAX};     // extremes pair up
    send_set(vals);
    vals = '{1, 2, 3};                 // no match
    send_set(vals);
    write_target(VAL_MAX);
    vals = '{-1, 0, VAL_MAX, VAL_MAX}; // 0 and VAL_MAX pair up; the two maxima are never added
    send_set(vals);
    write_target(VAL_MIN);
    vals = '{VAL_MIN, 0, 0};
    send_set(vals);
    vals = '{VAL_MIN, VAL_MIN};        // sum below the most negative target
    send_set(vals);
    vals = '{9, VAL_MIN, -4, 5};       // unsorted
    send_set(vals);

    // full store pairing up to the result cap, then two beats dropped
    write_target(63);
    vals.delete();
    for (int i = 0; i < 66; i++) vals.push_back(i < 64 ? i : 100 + i);
    send_set(vals);

    // long receiver hold while the sender keeps offering the next set
    write_target(15);
    gapless      = 1'b1;
    hold_off_req = 1'b1;
    vals.delete();
    for (int i = 0; i < 16; i++) vals.push_back(i);
    send_set(vals);
    make_set(6, 15, 1, vals);
    send_set(vals);
    gapless = 1'b0;

    while (beats_sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 5))
        0:       target = VAL_MIN;
        1:       target = VAL_MAX;
        2:       target = 0;
        3:       target = $urandom();
        default: target = int'($urandom_range(0, 200)) - 100;
      endcase
      write_target(target);
      repeat ($urandom_range(2, 4)) begin
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
        r = $urandom_range(0, 9);
        if (r < 4)      mode = 0;
        else if (r < 7) mode = 1;
        else if (r < 8) mode = 2;
        else            mode = 3;
        make_set(count, target, mode, vals);
        gapless = ($urandom_range(0, 3) == 0);
        send_set(vals);
      end
    end

    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
